// File: hdl/chromosome_name_to_code_assert.svh
// Assertion macros for the chromosome name to code block.
`ifndef CHROMOSOME_NAME_TO_CODE_ASSERT_SVH
`define CHROMOSOME_NAME_TO_CODE_ASSERT_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante.
`define CTN_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed in chromosome name to code block");

// Check that cons holds in the cycle after ante.
`define CTN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed in chromosome name to code block");

`else

`define CTN_ASSERT_SAME(label, ante, cons)
`define CTN_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: hdl/ctn_pkg.sv
// Types, character codes and keyword tables of the chromosome name parser.
package ctn_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned CODE_W  = 5;
  localparam int unsigned VALUE_W = 17;
  localparam int unsigned ACC_W   = 21;
  localparam int unsigned KPOS_W  = 3;
  localparam int unsigned FCNT_W  = 3;

  localparam logic [VALUE_W-1:0] VALUE_CAP   = 17'd131071;
  localparam logic [VALUE_W-1:0] VALUE_NC_MT = 17'd12920;

  localparam logic [CODE_W-1:0] CODE_NONE = 5'd0;
  localparam logic [CODE_W-1:0] CODE_X    = 5'd23;
  localparam logic [CODE_W-1:0] CODE_Y    = 5'd24;
  localparam logic [CODE_W-1:0] CODE_MT   = 5'd25;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LC_C  = 8'h63;
  localparam logic [CHAR_W-1:0] CH_LC_D  = 8'h64;
  localparam logic [CHAR_W-1:0] CH_LC_H  = 8'h68;
  localparam logic [CHAR_W-1:0] CH_LC_M  = 8'h6D;
  localparam logic [CHAR_W-1:0] CH_LC_N  = 8'h6E;
  localparam logic [CHAR_W-1:0] CH_LC_R  = 8'h72;
  localparam logic [CHAR_W-1:0] CH_LC_T  = 8'h74;
  localparam logic [CHAR_W-1:0] CH_LC_X  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LC_Y  = 8'h79;
  localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;

  localparam logic [KPOS_W-1:0] KW_SHORT_LEN = 3'd3;
  localparam logic [KPOS_W-1:0] KW_MT_LEN    = 3'd5;
  localparam logic [FCNT_W-1:0] NC_FIELD_LEN = 3'd6;

  typedef enum logic [3:0] {
    PH_LEAD      = 4'd0,
    PH_AFTER_CHR = 4'd1,
    PH_CHR_KW    = 4'd2,
    PH_NC_KW     = 4'd3,
    PH_NC_SKIP   = 4'd4,
    PH_NC_NUM    = 4'd5,
    PH_NC_DONE   = 4'd6,
    PH_NUM       = 4'd7,
    PH_X         = 4'd8,
    PH_Y         = 4'd9,
    PH_M         = 4'd10
  } ctn_phase_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              has_char;
    logic              last;
  } ctn_beat_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              valid_res;
  } ctn_res_t;

  function automatic logic [CHAR_W-1:0] ctn_to_lower(logic [CHAR_W-1:0] c);
    ctn_to_lower = (c >= CH_UP_A && c <= CH_UP_Z) ? (c + (CH_LC_A - CH_UP_A)) : c;
  endfunction

  function automatic logic [CHAR_W-1:0] ctn_kw_chr(logic [KPOS_W-1:0] pos);
    case (pos)
      3'd0:    ctn_kw_chr = CH_LC_C;
      3'd1:    ctn_kw_chr = CH_LC_H;
      3'd2:    ctn_kw_chr = CH_LC_R;
      default: ctn_kw_chr = '0;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] ctn_kw_nc(logic [KPOS_W-1:0] pos);
    case (pos)
      3'd0:    ctn_kw_nc = CH_LC_N;
      3'd1:    ctn_kw_nc = CH_LC_C;
      3'd2:    ctn_kw_nc = CH_UNDER;
      default: ctn_kw_nc = '0;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] ctn_kw_mt(logic [KPOS_W-1:0] pos);
    case (pos)
      3'd0:    ctn_kw_mt = CH_LC_M;
      3'd1:    ctn_kw_mt = CH_LC_T;
      3'd2:    ctn_kw_mt = CH_LC_D;
      3'd3:    ctn_kw_mt = CH_LC_N;
      3'd4:    ctn_kw_mt = CH_LC_A;
      default: ctn_kw_mt = '0;
    endcase
  endfunction

endpackage

// File: hdl/chromosome_name_to_code.sv
// Top level of the chromosome name to code parser.
//
//   chan  dir  handshake             fields
//   in    in   in_valid, in_stall    in_ch, in_has_char, in_last
//   out   out  out_valid, out_stall  out_code, out_valid_res
//
// One beat enters per cycle while in_stall is low; the per-character state update is
// combinational logic between the input register and the parser state.
// A result is loaded into the output register when its last beat leaves the input register.
// Synchronous reset clears the parser state and both valid flags.
// A held result stalls the input only when the waiting beat ends a token.
module chromosome_name_to_code (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ctn_pkg::CHAR_W-1:0]  in_ch,
  input  logic                        in_has_char,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ctn_pkg::CODE_W-1:0]  out_code,
  output logic                        out_valid_res
);
  import ctn_pkg::*;

  ctn_beat_t in_beat;
  ctn_beat_t s1_beat;
  ctn_res_t  res;
  logic      s1_valid;
  logic      s1_go;
  logic      can_load;

  assign in_beat.ch       = in_ch;
  assign in_beat.has_char = in_has_char;
  assign in_beat.last     = in_last;

  assign s1_go = s1_valid && (!s1_beat.last || can_load);

  ctn_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .s1_valid (s1_valid),
    .s1_beat  (s1_beat),
    .s1_go    (s1_go)
  );

  ctn_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (s1_go),
    .beat  (s1_beat),
    .res   (res)
  );

  ctn_out_stage u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (s1_go && s1_beat.last),
    .res           (res),
    .can_load      (can_load),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_code      (out_code),
    .out_valid_res (out_valid_res)
  );

endmodule

// File: hdl/ctn_in_stage.sv
// Input register stage: holds one accepted beat until the parser takes it.
module ctn_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ctn_pkg::ctn_beat_t  in_beat,
  output logic                s1_valid,
  output ctn_pkg::ctn_beat_t  s1_beat,
  input  logic                s1_go
);
  import ctn_pkg::*;

  logic      s1_valid_r;
  logic      s1_valid_nxt;
  ctn_beat_t s1_beat_r;
  logic      load;

  assign in_stall = s1_valid_r && !s1_go;
  assign load     = in_valid && !in_stall;

  always_comb begin
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_beat_r <= in_beat;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_beat  = s1_beat_r;

endmodule

// File: hdl/ctn_parser.sv
// Token parser: per-character state update and the code of a finished token.
module ctn_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  ctn_pkg::ctn_beat_t beat,
  output ctn_pkg::ctn_res_t  res
);
  import ctn_pkg::*;

  `include "chromosome_name_to_code_assert.svh"

  ctn_phase_t         phase_r, phase_nxt;
  logic [KPOS_W-1:0]  kpos_r, kpos_nxt;
  logic [VALUE_W-1:0] value_r, value_nxt;
  logic [FCNT_W-1:0]  fcnt_r, fcnt_nxt;
  logic               neg_r, neg_nxt;
  logic               blank_r, blank_nxt;
  logic               failed_r, failed_nxt;

  logic [CHAR_W-1:0]  c;
  logic [CHAR_W-1:0]  lc;
  logic               is_sp_tab;
  logic               is_blank;
  logic               is_digit;
  logic               is_sign;
  logic [ACC_W-1:0]   acc;
  logic [VALUE_W-1:0] digit_value;
  logic [CODE_W-1:0]  code;

  assign c         = beat.ch;
  assign lc        = ctn_to_lower(c);
  assign is_sp_tab = (c == CH_SPACE) || (c == CH_TAB);
  assign is_blank  = is_sp_tab || (c == CH_CR);
  assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_sign   = (c == CH_PLUS) || (c == CH_MINUS);

  assign acc = ({{(ACC_W-VALUE_W){1'b0}}, value_r} << 3)
             + ({{(ACC_W-VALUE_W){1'b0}}, value_r} << 1)
             + {{(ACC_W-4){1'b0}}, c[3:0]};
  assign digit_value = (acc > {{(ACC_W-VALUE_W){1'b0}}, VALUE_CAP}) ? VALUE_CAP
                                                                    : acc[VALUE_W-1:0];

  // next state: consume one character
  always_comb begin
    phase_nxt  = phase_r;
    kpos_nxt   = kpos_r;
    value_nxt  = value_r;
    fcnt_nxt   = fcnt_r;
    neg_nxt    = neg_r;
    blank_nxt  = blank_r;
    failed_nxt = failed_r;
    if (beat.has_char && !failed_r) begin
      case (phase_r)
        PH_LEAD, PH_AFTER_CHR: begin
          if (!is_sp_tab) begin
            if (lc == CH_LC_C && phase_r == PH_LEAD) begin
              phase_nxt = PH_CHR_KW;
              kpos_nxt  = 3'd1;
            end else if (lc == CH_LC_N) begin
              phase_nxt = PH_NC_KW;
              kpos_nxt  = 3'd1;
            end else if (lc == CH_LC_X) begin
              phase_nxt = PH_X;
            end else if (lc == CH_LC_Y) begin
              phase_nxt = PH_Y;
            end else if (lc == CH_LC_M) begin
              phase_nxt = PH_M;
              kpos_nxt  = 3'd1;
            end else if (is_sign) begin
              phase_nxt = PH_NUM;
              neg_nxt   = (c == CH_MINUS);
              kpos_nxt  = 3'd0;
            end else if (is_digit) begin
              phase_nxt = PH_NUM;
              value_nxt = digit_value;
              kpos_nxt  = 3'd1;
            end else begin
              failed_nxt = 1'b1;
            end
          end
        end
        PH_CHR_KW: begin
          if (kpos_r < KW_SHORT_LEN && lc == ctn_kw_chr(kpos_r)) begin
            if (kpos_r == KW_SHORT_LEN - 3'd1) begin
              phase_nxt = PH_AFTER_CHR;
              kpos_nxt  = 3'd0;
            end else begin
              kpos_nxt = kpos_r + 3'd1;
            end
          end else begin
            failed_nxt = 1'b1;
          end
        end
        PH_NC_KW: begin
          if (kpos_r < KW_SHORT_LEN && lc == ctn_kw_nc(kpos_r)) begin
            if (kpos_r == KW_SHORT_LEN - 3'd1) begin
              phase_nxt = PH_NC_SKIP;
              kpos_nxt  = 3'd0;
            end else begin
              kpos_nxt = kpos_r + 3'd1;
            end
          end else begin
            failed_nxt = 1'b1;
          end
        end
        PH_NC_SKIP: begin
          if (!is_sp_tab) begin
            if (is_sign) begin
              neg_nxt   = (c == CH_MINUS);
              fcnt_nxt  = 3'd1;
              phase_nxt = PH_NC_NUM;
            end else if (is_digit) begin
              value_nxt = digit_value;
              kpos_nxt  = 3'd1;
              fcnt_nxt  = 3'd1;
              phase_nxt = PH_NC_NUM;
            end else begin
              failed_nxt = 1'b1;
            end
          end
        end
        PH_NC_NUM: begin
          if (is_blank) begin
            blank_nxt = 1'b1;
          end else if (blank_r || !is_digit) begin
            failed_nxt = 1'b1;
          end else begin
            value_nxt = digit_value;
            kpos_nxt  = 3'd1;
          end
          fcnt_nxt = fcnt_r + 3'd1;
          if (fcnt_r >= NC_FIELD_LEN - 3'd1) begin
            phase_nxt = PH_NC_DONE;
          end
        end
        PH_NC_DONE: begin
          if (!is_blank) begin
            blank_nxt = 1'b0;
          end
        end
        PH_NUM: begin
          if (is_blank) begin
            blank_nxt = 1'b1;
          end else if (blank_r || !is_digit) begin
            failed_nxt = 1'b1;
          end else begin
            value_nxt = digit_value;
            kpos_nxt  = 3'd1;
          end
        end
        PH_X, PH_Y: begin
          if (!is_blank) begin
            failed_nxt = 1'b1;
          end
        end
        PH_M: begin
          if (is_blank) begin
            blank_nxt = 1'b1;
          end else if (blank_r || kpos_r >= KW_MT_LEN || lc != ctn_kw_mt(kpos_r)) begin
            failed_nxt = 1'b1;
          end else begin
            kpos_nxt = kpos_r + 3'd1;
          end
        end
        default: begin
          failed_nxt = 1'b1;
        end
      endcase
    end
  end

  // outputs: code of the token as it stands after this character
  always_comb begin
    code = CODE_NONE;
    if (!failed_nxt) begin
      case (phase_nxt)
        PH_NC_DONE: begin
          if (!(blank_nxt || kpos_nxt == 3'd0 || neg_nxt)) begin
            if (value_nxt >= 17'd1 && value_nxt <= 17'd24) begin
              code = value_nxt[CODE_W-1:0];
            end else if (value_nxt == VALUE_NC_MT) begin
              code = CODE_MT;
            end
          end
        end
        PH_NUM: begin
          if (kpos_nxt != 3'd0 && !neg_nxt && value_nxt >= 17'd1 && value_nxt <= 17'd25) begin
            code = value_nxt[CODE_W-1:0];
          end
        end
        PH_X: code = CODE_X;
        PH_Y: code = CODE_Y;
        PH_M: begin
          if (kpos_nxt == 3'd1 || kpos_nxt == 3'd2 || kpos_nxt == KW_MT_LEN) begin
            code = CODE_MT;
          end
        end
        default: code = CODE_NONE;
      endcase
    end
  end

  assign res.code      = code;
  assign res.valid_res = (code != CODE_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n || (go && beat.last)) begin
      phase_r  <= PH_LEAD;
      kpos_r   <= '0;
      value_r  <= '0;
      fcnt_r   <= '0;
      neg_r    <= 1'b0;
      blank_r  <= 1'b0;
      failed_r <= 1'b0;
    end else if (go) begin
      phase_r  <= phase_nxt;
      kpos_r   <= kpos_nxt;
      value_r  <= value_nxt;
      fcnt_r   <= fcnt_nxt;
      neg_r    <= neg_nxt;
      blank_r  <= blank_nxt;
      failed_r <= failed_nxt;
    end
  end

  `CTN_ASSERT_NEXT(a_clear_after_last, go && beat.last, phase_r == PH_LEAD && !failed_r && value_r == '0)
  `CTN_ASSERT_NEXT(a_failed_freezes, go && !beat.last && failed_r, failed_r && $stable(phase_r) && $stable(value_r))
  `CTN_ASSERT_SAME(a_code_range, go && beat.last, code <= CODE_MT)
  `CTN_ASSERT_SAME(a_failed_no_code, failed_nxt, code == CODE_NONE)

endmodule

// File: hdl/ctn_out_stage.sv
// Result register: holds one result beat until the receiver takes it.
module ctn_out_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  ctn_pkg::ctn_res_t           res,
  output logic                        can_load,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ctn_pkg::CODE_W-1:0]  out_code,
  output logic                        out_valid_res
);
  import ctn_pkg::*;

  logic     out_valid_r;
  logic     out_valid_nxt;
  ctn_res_t res_r;

  assign can_load = !out_valid_r || !out_stall;

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_code      = res_r.code;
  assign out_valid_res = res_r.valid_res;

endmodule
